FILE: design/liu_pkg.sv
// ----------------------------------------------------------------------------
// liu_pkg: shared definitions for the linear interpolation upsampler
// Register map, CSR bus types and the factor register layout.
// ----------------------------------------------------------------------------
`default_nettype none

package liu_pkg;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 1;

   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   // byte address of the factor register
   localparam csr_addr_type CSR_FACTOR_ADDR = '0;

   localparam int FACTOR_WIDTH = 6;

   typedef logic [FACTOR_WIDTH-1:0] factor_type;

   localparam factor_type FACTOR_RESET = 6'd1;

endpackage : liu_pkg

`default_nettype wire

FILE: design/linear_interp_upsampler.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler: one-channel linear interpolation upsampler
// Emits factor samples per input sample after the first, interpolated
// between previous and current input, with an extrapolated tail at signal end.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input samples. A transaction completes when req_valid is high
//            and req_stall is low. req_stall is high while an item is being
//            worked on.
//   rsp_*  : output samples, one transaction per interpolated sample, held in
//            an output register that the receiver drains via rsp_stall.
//   psel.. : APB-style CSR port, factor register at byte address 0.
//            Write only while the block is idle.
// Operation, with D the effective factor (1..MAX_FACTOR):
//   first sample of a signal: stored, no output (alone, a flat run of D).
//   other samples: accepted, then divided in the restoring
//   divider (|diff| / D, one quotient bit per cycle), then D
//   output samples, or 2*D on end of signal.
// Reset: synchronous, clears state, factor returns to 1, no pending output.
// Receiver stall: the output register holds its sample and the sequencer
// waits; nothing is dropped. A new input is taken while the final output of
// the previous one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_upsampler #(
   parameter int MAX_FACTOR   = 32,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // input channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  signed [SAMPLE_WIDTH-1:0]   req_in_sample,
   input  wire                              req_end_of_signal,
   // output channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_out_sample,
   output logic                             rsp_run_last,
   output logic                             rsp_signal_last,
   // CSR port
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  liu_pkg::csr_addr_type      paddr,
   input  wire  liu_pkg::csr_data_type      pwdata,
   output liu_pkg::csr_data_type            prdata,
   output logic                             pready
);

   import liu_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int DW = SAMPLE_WIDTH + 1;         // |diff| and quotient
   localparam int OW = SAMPLE_WIDTH + 2;         // unsaturated sum
   localparam int FW = $clog2(MAX_FACTOR + 1);   // effective factor
   localparam int RW = $clog2(4 * MAX_FACTOR);   // rounding remainder
   localparam int CW = $clog2(DW + 1);           // divider step count

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   factor_type               factor_ff, factor_in;
   logic signed [SW-1:0]     prev_ff, prev_in;
   logic                     have_prev_ff, have_prev_in;
   logic signed [SW-1:0]     base_ff, base_in;   // start of current segment
   logic signed [SW-1:0]     next_ff, next_in;   // base of extrapolated tail
   logic                     neg_ff, neg_in;
   logic                     eos_ff, eos_in;
   logic                     seg2_ff, seg2_in;   // tail segment still to go
   logic [DW-1:0]            dq_ff, dq_in;       // dividend in, quotient out
   logic [FW-1:0]            rem_ff, rem_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [DW-1:0]            q_ff, q_in;         // round(|diff|*j/D)
   logic [RW-1:0]            r_ff, r_in;
   logic [FW-1:0]            j_ff, j_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                     rsp_run_last_ff, rsp_run_last_in;
   logic                     rsp_signal_last_ff, rsp_signal_last_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     csr_write;
   logic [FW-1:0]            d_eff;
   logic signed [DW-1:0]     diff_w;
   logic [DW-1:0]            abs_diff;
   logic [FW:0]              trial;
   logic [FW:0]              trial_sub;
   logic                     trial_ge;
   logic [RW-1:0]            r_sum;
   logic [RW-1:0]            two_d;
   logic                     r_wrap;
   logic [OW-1:0]            base_ext;
   logic [OW-1:0]            q_ext;
   logic [OW-1:0]            value;
   logic signed [SW-1:0]     value_sat;
   logic                     last_j;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_signal_last = rsp_signal_last_ff;

   // CSR access, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr == CSR_FACTOR_ADDR) ?
                      CSR_DATA_WIDTH'(factor_ff) : '0;

   // zero means 1, anything above the maximum is clamped
   always_comb begin
      if (factor_ff == '0) begin
         d_eff = FW'(1);
      end else if (factor_ff > FACTOR_WIDTH'(MAX_FACTOR)) begin
         d_eff = FW'(MAX_FACTOR);
      end else begin
         d_eff = factor_ff[FW-1:0];
      end
   end

   assign diff_w   = {req_in_sample[SW-1], req_in_sample} - {prev_ff[SW-1], prev_ff};
   assign abs_diff = diff_w[DW-1] ? DW'(-diff_w) : DW'(diff_w);

   // restoring divider step: one quotient bit per cycle
   assign trial     = {rem_ff, dq_ff[DW-1]};
   assign trial_sub = trial - {1'b0, d_eff};
   assign trial_ge  = (trial >= {1'b0, d_eff});

   // rounding tracker: numerator 2*|diff|*j + D kept as q*2D + r
   assign r_sum  = r_ff + RW'({rem_ff, 1'b0});
   assign two_d  = RW'({d_eff, 1'b0});
   assign r_wrap = (r_sum >= two_d);

   // output value with saturation
   assign base_ext = {{2{base_ff[SW-1]}}, base_ff};
   assign q_ext    = {1'b0, q_ff};
   assign value    = neg_ff ? (base_ext - q_ext) : (base_ext + q_ext);

   always_comb begin
      if ((value[OW-1] != value[OW-2]) || (value[OW-2] != value[OW-3])) begin
         value_sat = value[OW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         value_sat = value[SW-1:0];
      end
   end

   assign last_j = (j_ff == d_eff - FW'(1));

   always_comb begin
      state_in           = state_ff;
      factor_in          = factor_ff;
      prev_in            = prev_ff;
      have_prev_in       = have_prev_ff;
      base_in            = base_ff;
      next_in            = next_ff;
      neg_in             = neg_ff;
      eos_in             = eos_ff;
      seg2_in            = seg2_ff;
      dq_in              = dq_ff;
      rem_in             = rem_ff;
      cnt_in             = cnt_ff;
      q_in               = q_ff;
      r_in               = r_ff;
      j_in               = j_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_sample_in      = rsp_sample_ff;
      rsp_run_last_in    = rsp_run_last_ff;
      rsp_signal_last_in = rsp_signal_last_ff;

      if (csr_write && (paddr == CSR_FACTOR_ADDR)) begin
         factor_in = pwdata[FACTOR_WIDTH-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // end of signal clears the history right away
               prev_in      = req_end_of_signal ? '0 : req_in_sample;
               have_prev_in = !req_end_of_signal;
               eos_in       = req_end_of_signal;
               rem_in       = '0;
               cnt_in       = '0;
               q_in         = '0;
               r_in         = RW'(d_eff);
               j_in         = '0;
               if (have_prev_ff) begin
                  base_in  = prev_ff;
                  next_in  = req_in_sample;
                  neg_in   = diff_w[DW-1];
                  dq_in    = abs_diff;
                  seg2_in  = req_end_of_signal;
                  state_in = ST_DIV;
               end else if (req_end_of_signal) begin
                  // one-sample signal: flat run of the sample itself
                  base_in  = req_in_sample;
                  next_in  = req_in_sample;
                  neg_in   = 1'b0;
                  dq_in    = '0;
                  seg2_in  = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[FW-1:0] : trial[FW-1:0];
            dq_in  = {dq_ff[DW-2:0], trial_ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_sample_in      = value_sat;
               rsp_run_last_in    = last_j && !seg2_ff;
               rsp_signal_last_in = last_j && !seg2_ff && eos_ff;
               q_in = q_ff + dq_ff + DW'(r_wrap);
               r_in = r_wrap ? (r_sum - two_d) : r_sum;
               j_in = j_ff + FW'(1);
               if (last_j) begin
                  if (seg2_ff) begin
                     // extrapolated tail from the new sample, same slope
                     seg2_in = 1'b0;
                     base_in = next_ff;
                     q_in    = '0;
                     r_in    = RW'(d_eff);
                     j_in    = '0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= FACTOR_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff            <= base_in;
      next_ff            <= next_in;
      neg_ff             <= neg_in;
      eos_ff             <= eos_in;
      seg2_ff            <= seg2_in;
      dq_ff              <= dq_in;
      rem_ff             <= rem_in;
      cnt_ff             <= cnt_in;
      q_ff               <= q_in;
      r_ff               <= r_in;
      j_ff               <= j_in;
      rsp_sample_ff      <= rsp_sample_in;
      rsp_run_last_ff    <= rsp_run_last_in;
      rsp_signal_last_ff <= rsp_signal_last_in;
   end

endmodule : linear_interp_upsampler

`default_nettype wire
